// ----- hw/rtl/bqrms_pkg.sv -----
// shared constants, types and coefficient table of the biquad cascade rms meter
// no dependencies
`default_nettype none
package bqrms_pkg;
  localparam int Sections = 5;
  localparam int Window = 64;
  localparam int SampleWidth = 24;
  localparam int FracBits = SampleWidth - 4;
  localparam int SqFrac = 28;
  localparam int RomRows = 5;
  localparam int SecW = $clog2(Sections);
  localparam int WinW = $clog2(Window);
  localparam int HistDepth = 4 * Sections;
  localparam int HistW = $clog2(HistDepth);
  localparam int SumW = 32 + WinW;
  localparam int AccW = SampleWidth + 18 + 4;
  localparam int SqW = 2 * SampleWidth;
  localparam int SqShift = 2 * FracBits - SqFrac;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [17:0] coef_t;

  // coefficient term: 0 b0, 1 b1, 2 b2, 3 a1, 4 a2
  function automatic coef_t coef(input logic [SecW-1:0] sec, input logic [2:0] term);
    logic [SecW-1:0] r;
    logic [2:0] row;
    coef_t c;
    // fold the section index onto the rom rows by repeated subtraction
    r = sec;
    for (int i = 0; i < 3; i++) begin
      if (32'(r) >= RomRows) r = r - SecW'(RomRows);
    end
    row = 3'(r);
    c = '0;
    case (row)
      3'd0: case (term)
        3'd0: c = 18'sd18630; 3'd1: c = 18'sd37261; 3'd2: c = 18'sd18630;
        3'd3: c = -18'sd83687; default: c = 18'sd48106;
      endcase
      3'd1: case (term)
        3'd0: c = 18'sd18630; 3'd1: c = -18'sd37261; 3'd2: c = 18'sd18630;
        3'd3: c = -18'sd126318; default: c = 18'sd61833;
      endcase
      3'd2: case (term)
        3'd0: c = 18'sd16672; 3'd1: c = 18'sd33344; 3'd2: c = 18'sd16672;
        3'd3: c = -18'sd118041; default: c = 18'sd53837;
      endcase
      3'd3: case (term)
        3'd0: c = 18'sd16672; 3'd1: c = -18'sd33344; 3'd2: c = 18'sd16672;
        3'd3: c = -18'sd74964; default: c = 18'sd28356;
      endcase
      default: case (term)
        3'd0: c = 18'sd16072; 3'd1: c = 18'sd0; 3'd2: c = -18'sd16072;
        3'd3: c = -18'sd94086; default: c = 18'sd33392;
      endcase
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/bqrms_isqrt.sv -----
// iterative integer square root, one result bit per cycle
// no dependencies
`default_nettype none
module bqrms_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] value,
  output logic             done,
  output logic [15:0]      root
);
  logic [31:0] rem;
  logic [31:0] acc;
  logic [31:0] bit_mask;
  logic        busy;

  // one digit per cycle
  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (bit_mask == 32'd1);
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy     <= 1'b1;
      rem      <= value;
      acc      <= '0;
      bit_mask <= 32'h4000_0000;
    end else if (busy) begin
      if (rem >= acc + bit_mask) begin
        rem <= rem - (acc + bit_mask);
        acc <= (acc >> 1) + bit_mask;
      end else begin
        acc <= acc >> 1;
      end
      bit_mask <= bit_mask >> 2;
      if (bit_mask == 32'd1) begin
        busy <= 1'b0;
      end
    end
  end

  assign root = acc[15:0];
endmodule
`default_nettype wire

// ----- hw/rtl/bqrms_filter.sv -----
// biquad cascade on one shared multiplier, histories held in a synchronous memory
// depends on bqrms_pkg
`default_nettype none
module bqrms_filter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [11:0]        adc_sample,
  output logic                    done,
  output bqrms_pkg::sample_t      y_out
);
  typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_SCALE, S_READ, S_MAC, S_STORE} state_t;
  state_t state;

  // history memory: per section x1, x2, y1, y2
  bqrms_pkg::sample_t hist_mem [bqrms_pkg::HistDepth];
  bqrms_pkg::sample_t rd_data;
  logic [bqrms_pkg::HistW-1:0] rd_addr;
  logic [bqrms_pkg::HistW-1:0] wr_addr;
  logic                        wr_en;
  bqrms_pkg::sample_t          wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) hist_mem[wr_addr] <= wr_data;
    rd_data <= hist_mem[rd_addr];
  end

  logic [bqrms_pkg::HistW-1:0] clr_cnt;
  logic [bqrms_pkg::SecW-1:0]  sec;
  logic [2:0]                  term;
  logic [2:0]                  wterm;
  bqrms_pkg::sample_t          x_cur;
  bqrms_pkg::sample_t          hist [4];
  logic signed [bqrms_pkg::AccW-1:0] acc;
  logic [11:0]                 adc_q;
  logic [32:0]                 scale_num;

  // scale: round(adc * 2^F / 4095) by reciprocal multiplication
  localparam int RecipShift = 44;
  localparam logic [33:0] Recip = 34'((64'd1 << RecipShift) / 64'd4095 + 64'd1);
  logic [67:0] scale_prod;
  logic [32:0] quot;
  assign scale_num = (33'(adc_q) << bqrms_pkg::FracBits) + 33'd2047;
  assign scale_prod = 68'(scale_num) * 68'(Recip);
  assign quot = 33'(scale_prod >> RecipShift);

  // multiplier operand for the current term
  bqrms_pkg::sample_t opnd;
  logic signed [bqrms_pkg::SampleWidth+17:0] prod;
  always_comb begin
    case (term)
      3'd0: opnd = x_cur;
      3'd1: opnd = hist[0];
      3'd2: opnd = hist[1];
      3'd3: opnd = hist[2];
      default: opnd = hist[3];
    endcase
  end
  assign prod = opnd * bqrms_pkg::coef(sec, term);

  // requantise and saturate the section sum
  localparam logic signed [bqrms_pkg::AccW-1:0] Hi =
    bqrms_pkg::AccW'((64'sd1 <<< (bqrms_pkg::SampleWidth - 1)) - 1);
  localparam logic signed [bqrms_pkg::AccW-1:0] Lo = -Hi - 1;
  logic signed [bqrms_pkg::AccW-1:0] rq;
  bqrms_pkg::sample_t y_sat;
  assign rq = (acc + bqrms_pkg::AccW'(32'sh8000)) >>> 16;
  assign y_sat = (rq > Hi) ? Hi[bqrms_pkg::SampleWidth-1:0] :
                 (rq < Lo) ? Lo[bqrms_pkg::SampleWidth-1:0] :
                 rq[bqrms_pkg::SampleWidth-1:0];

  always_comb begin
    wr_en = 1'b0;
    wr_addr = clr_cnt;
    wr_data = '0;
    rd_addr = bqrms_pkg::HistW'({sec, 2'b00} + 32'(term));
    case (state)
      S_CLEAR: wr_en = 1'b1;
      S_STORE: begin
        wr_en = 1'b1;
        wr_addr = bqrms_pkg::HistW'(32'(sec) * 4 + 32'(wterm));
        case (wterm)
          3'd0: wr_data = x_cur;
          3'd1: wr_data = hist[0];
          3'd2: wr_data = y_sat;
          default: wr_data = hist[2];
        endcase
      end
      default: ;
    endcase
  end

  // sequencer: per section read four, five products, write back four
  always_ff @(posedge clk) begin
    done <= !rst && (state == S_STORE) && (wterm == 3'd3) &&
            (32'(sec) == bqrms_pkg::Sections - 1);
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (32'(clr_cnt) == bqrms_pkg::HistDepth - 1) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          adc_q <= adc_sample;
          state <= S_SCALE;
        end
        S_SCALE: begin
          x_cur <= bqrms_pkg::SampleWidth'(quot);
          sec   <= '0;
          term  <= 3'd0;
          state <= S_READ;
        end
        S_READ: begin
          // read address term, data arrives next cycle
          if (term != 3'd0) hist[2'(term - 3'd1)] <= rd_data;
          if (term == 3'd4) begin
            term  <= 3'd0;
            acc   <= '0;
            state <= S_MAC;
          end else begin
            term <= term + 3'd1;
          end
        end
        S_MAC: begin
          if (term >= 3'd3) acc <= acc - bqrms_pkg::AccW'(prod);
          else acc <= acc + bqrms_pkg::AccW'(prod);
          if (term == 3'd4) begin
            wterm <= 3'd0;
            state <= S_STORE;
          end else begin
            term <= term + 3'd1;
          end
        end
        S_STORE: begin
          wterm <= wterm + 3'd1;
          if (wterm == 3'd3) begin
            x_cur <= y_sat;
            term  <= 3'd0;
            if (32'(sec) == bqrms_pkg::Sections - 1) begin
              y_out <= y_sat;
              state <= S_IDLE;
            end else begin
              sec   <= sec + 1'b1;
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/bqrms_window.sv -----
// square, sliding window memory of squares and exact running sum
// depends on bqrms_pkg
`default_nettype none
module bqrms_window (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire bqrms_pkg::sample_t y_in,
  output logic                    ready,
  output logic                    done,
  output logic [31:0]             mean
);
  typedef enum logic [2:0] {W_CLEAR, W_IDLE, W_SQ, W_READ, W_UPD} state_t;
  state_t state;

  logic [31:0] win_mem [bqrms_pkg::Window];
  logic [31:0] rd_data;
  logic [bqrms_pkg::WinW-1:0] pos;
  logic [bqrms_pkg::WinW-1:0] wr_addr;
  logic        wr_en;
  logic [31:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) win_mem[wr_addr] <= wr_data;
    rd_data <= win_mem[pos];
  end

  logic [bqrms_pkg::SampleWidth-1:0] mag;
  logic [bqrms_pkg::SqW-1:0] sq_full;
  logic [bqrms_pkg::SqW-1:0] sq_rnd;
  logic [31:0] sq;
  logic [bqrms_pkg::SumW-1:0] sum;
  logic [bqrms_pkg::SumW-1:0] sum_new;

  assign sq_rnd = (sq_full + (bqrms_pkg::SqW'(1) << (bqrms_pkg::SqShift - 1)))
                  >> bqrms_pkg::SqShift;
  assign sum_new = sum - bqrms_pkg::SumW'(rd_data) + bqrms_pkg::SumW'(sq);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = pos;
    wr_data = sq;
    if (state == W_CLEAR) begin
      wr_en = 1'b1;
      wr_data = '0;
    end else if (state == W_UPD) begin
      wr_en = 1'b1;
    end
  end

  assign ready = (state == W_IDLE);

  // clear pass, then per sample: square, read old slot, update
  always_ff @(posedge clk) begin
    done <= !rst && (state == W_UPD);
    if (rst) begin
      state <= W_CLEAR;
      pos   <= '0;
      sum   <= '0;
    end else begin
      case (state)
        W_CLEAR: begin
          pos <= pos + 1'b1;
          if (32'(pos) == bqrms_pkg::Window - 1) state <= W_IDLE;
        end
        W_IDLE: if (start) begin
          mag   <= y_in[bqrms_pkg::SampleWidth-1] ? -y_in : y_in;
          state <= W_SQ;
        end
        W_SQ: begin
          sq_full <= mag * mag;
          state   <= W_READ;
        end
        W_READ: begin
          sq    <= (|sq_rnd[bqrms_pkg::SqW-1:32]) ? 32'hFFFF_FFFF : sq_rnd[31:0];
          state <= W_UPD;
        end
        W_UPD: begin
          sum  <= sum_new;
          mean <= 32'(sum_new >> bqrms_pkg::WinW);
          pos  <= pos + 1'b1;
          state <= W_IDLE;
        end
        default: state <= W_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/biquad_cascade_moving_rms.sv -----
// top level: stream ports, filter cascade, rms window and square root
// depends on bqrms_pkg, bqrms_filter, bqrms_window, bqrms_isqrt
//
// channel   direction  tdata bits           handshake
// s_axis    in         [11:0] adc_sample    tvalid/tready
// m_axis    out        [15:0] rms_level     tvalid/tready
//
// after a request is accepted, a level is produced by one scaling step,
// five sections of fourteen steps (five reads, five products, four write-backs),
// the window steps, the root steps and one output step. requests are handled
// one at a time; the next can be taken in the cycle that the level appears.
// after reset clearing passes run over the window and filter history memories.
// a level waits in the output register while the next request is taken; a second
// finished level is held back and the input stalls until the register is free.
`default_nettype none
module biquad_cascade_moving_rms (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [11:0] adc_sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // [15:0] rms_level
);
  logic busy;
  logic f_done;
  bqrms_pkg::sample_t f_y;
  logic w_ready, w_done;
  logic [31:0] w_mean;
  logic r_done;
  logic [15:0] r_root;
  logic out_full;
  logic [15:0] root_raw;
  logic root_done_raw;

  // one request in flight; out register may still hold the prior result
  assign s_axis_tready = !busy && w_ready && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) busy <= 1'b1;
      else if (r_done && (!out_full || m_axis_tready)) busy <= 1'b0;
      if (r_done && (!out_full || m_axis_tready)) begin
        out_full <= 1'b1;
        m_axis_tdata <= r_root;
      end else if (m_axis_tready) begin
        out_full <= 1'b0;
      end
    end
  end

  // hold root done until the output register is free
  logic r_hold;
  logic [15:0] root_q;
  always_ff @(posedge clk) begin
    if (rst) r_hold <= 1'b0;
    else if (r_done && out_full && !m_axis_tready) begin
      r_hold <= 1'b1;
      root_q <= r_root;
    end else if (r_hold && m_axis_tready) r_hold <= 1'b0;
  end
  logic [15:0] root_mux;
  assign root_mux = r_hold ? root_q : root_raw;
  assign r_done = root_done_raw || r_hold;
  assign r_root = root_mux;
  assign m_axis_tvalid = out_full;

  bqrms_filter u_filter (
    .clk(clk), .rst(rst),
    .start(s_axis_tvalid && s_axis_tready),
    .adc_sample(s_axis_tdata[11:0]),
    .done(f_done), .y_out(f_y)
  );

  bqrms_window u_window (
    .clk(clk), .rst(rst), .start(f_done), .y_in(f_y),
    .ready(w_ready), .done(w_done), .mean(w_mean)
  );

  bqrms_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(w_done), .value(w_mean),
    .done(root_done_raw), .root(root_raw)
  );
endmodule
`default_nettype wire

// ----- test/biquad_cascade_moving_rms_tb.sv -----
// testbench of the biquad cascade rms meter: random and directed converter samples,
// each result checked against a fixed-point model of the filter chain and window
// depends on bqrms_pkg and biquad_cascade_moving_rms
`timescale 1ns / 1ps
`default_nettype none

module biquad_cascade_moving_rms_tb;

  // model of the filter cascade and rms window, with a queue of expected levels
  class rms_scoreboard;
    longint xh[bqrms_pkg::Sections][2];
    longint yh[bqrms_pkg::Sections][2];
    longint unsigned sq_win[bqrms_pkg::Window];
    longint unsigned sq_sum;
    int win_pos;
    logic [15:0] level_q[$];
    int mismatches;

    function void clear();
      for (int k = 0; k < bqrms_pkg::Sections; k++) begin
        xh[k][0] = 0; xh[k][1] = 0; yh[k][0] = 0; yh[k][1] = 0;
      end
      for (int i = 0; i < bqrms_pkg::Window; i++) sq_win[i] = 0;
      sq_sum = 0;
      win_pos = 0;
      mismatches = 0;
    endfunction

    // round to the sample grid and saturate
    function longint requant(longint acc);
      longint hi, lo, r;
      hi = (longint'(1) <<< (bqrms_pkg::SampleWidth - 1)) - 1;
      lo = -hi - 1;
      r = (acc + 32768) >>> 16;
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      return r;
    endfunction

    function logic [15:0] root(longint unsigned v);
      longint unsigned rem, rt, b;
      rem = v; rt = 0; b = 64'd1 << 30;
      while (b > rem) b >>= 2;
      while (b != 0) begin
        if (rem >= rt + b) begin
          rem -= rt + b;
          rt = (rt >> 1) + b;
        end else begin
          rt >>= 1;
        end
        b >>= 2;
      end
      return rt[15:0];
    endfunction

    function void note_sample(logic [11:0] adc);
      longint v, acc, y;
      longint c[5];
      longint unsigned m, sq, mean;
      int sh;
      v = longint'(((longint'(adc) << bqrms_pkg::FracBits) + 2047) / 4095);
      for (int k = 0; k < bqrms_pkg::Sections; k++) begin
        for (int t = 0; t < 5; t++)
          c[t] = longint'(bqrms_pkg::coef(bqrms_pkg::SecW'(k), 3'(t)));
        acc = c[0] * v + c[1] * xh[k][0] + c[2] * xh[k][1]
            - c[3] * yh[k][0] - c[4] * yh[k][1];
        y = requant(acc);
        xh[k][1] = xh[k][0]; xh[k][0] = v;
        yh[k][1] = yh[k][0]; yh[k][0] = y;
        v = y;
      end
      m = (v < 0) ? longint'(-v) : v;
      sq = m * m;
      sh = 2 * bqrms_pkg::FracBits - bqrms_pkg::SqFrac;
      if (sh > 0) sq = (sq + (64'd1 << (sh - 1))) >> sh;
      else if (sh < 0) sq <<= -sh;
      if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
      sq_sum = sq_sum - sq_win[win_pos] + sq;
      sq_win[win_pos] = sq;
      win_pos = (win_pos + 1) % bqrms_pkg::Window;
      mean = sq_sum / bqrms_pkg::Window;
      if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
      level_q.push_back(root(mean));
    endfunction

    function void check_level(logic [15:0] got);
      logic [15:0] want;
      if (level_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", got);
        return;
      end
      want = level_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("rms_level mismatch: expected %0d got %0d", want, got);
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [15:0] m_axis_tdata;
  rms_scoreboard sb;
  bit hold_off;
  int hold_cycles;

  biquad_cascade_moving_rms dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("biquad_cascade_moving_rms_tb failed");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 5) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(60, 300);
    return $urandom_range(1, 6);
  endfunction

  // send one request, upper tdata bits random since the block ignores them;
  // tvalid stays high into the next request when there is no gap
  task automatic send_sample(logic [11:0] adc);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'($urandom), adc};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_sample(adc);
  endtask

  // drop tvalid and wait until every expected level has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.level_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls of mostly short length, plus a long hold-off when asked
  initial begin
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) sb.check_level(m_axis_tdata[15:0]);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        hold_cycles++;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else if ($urandom_range(0, 9) < 3) begin
        m_axis_tready <= 1'b0;
        stall = gap_len();
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [11:0] adc;
    int t;
    sb = new();
    sb.clear();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    hold_off = 1'b0;
    hold_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, full-scale steps to push sections and squares to saturation
    for (int i = 0; i < 12; i++) send_sample(12'(1 << i));
    repeat (6) send_sample(12'hFFF);
    repeat (3) send_sample(12'h000);
    send_sample(12'hFFF);
    send_sample(12'h000);
    send_sample(12'hFFF);

    // sender pauses until every level has come out
    drain();

    // long receiver stall while requests keep coming
    hold_off = 1'b1;
    fork
      begin
        wait (hold_cycles >= 400);
        hold_off = 1'b0;
      end
      repeat (8) send_sample(12'($urandom));
    join

    // random: bursts of full-scale square waves, noise, slow ramps and full-scale or near-zero mixes
    t = 0;
    while (t < 1000) begin
      case ($urandom_range(0, 3))
        0: for (int i = 0; i < 16 && t < 1000; i++, t++)
             send_sample(((i / $urandom_range(1, 4)) % 2) ? 12'hFFF : 12'h000);
        1: for (int i = 0; i < 16 && t < 1000; i++, t++)
             send_sample(12'($urandom));
        2: begin
          adc = 12'($urandom);
          for (int i = 0; i < 16 && t < 1000; i++, t++) begin
            send_sample(adc);
            adc = adc + 12'($urandom_range(0, 300));
          end
        end
        default: for (int i = 0; i < 8 && t < 1000; i++, t++)
          send_sample(12'($urandom_range(0, 1) ? 12'hFFF : $urandom_range(0, 15)));
      endcase
    end

    s_axis_tvalid <= 1'b0;
    fork
      begin
        while (sb.level_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
      end
      begin
        repeat (200000) @(posedge clk);
      end
    join_any
    if (sb.level_q.size() == 0 && sb.mismatches == 0)
      $display("biquad_cascade_moving_rms_tb passed");
    else
      $display("biquad_cascade_moving_rms_tb failed");
    $finish;
  end
endmodule
`default_nettype wire
